@@ design/window_statistics_top_assert.svh @@
// ----------------------------------------------------------------------------
// Window statistics assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef WINDOW_STATISTICS_TOP_ASSERT_SVH
`define WINDOW_STATISTICS_TOP_ASSERT_SVH
`ifndef SYNTH
`define WST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WST_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define WST_ASSERT(lbl, prop, msg)
`define WST_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ design/wst_pkg.sv @@
// ----------------------------------------------------------------------------
// Window statistics package
// Widths, command codes and the item type shared by the block.
// ----------------------------------------------------------------------------
package wst_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int PTR_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int SQ_W        = 2 * SAMPLE_BITS + CNT_W - 2;
  localparam int D_W         = SQ_W + CNT_W;
  localparam int NN_W        = 2 * CNT_W;
  localparam int DVD_W       = D_W + 16;
  localparam int RAD_W       = 48;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_ADD_FIN = 2'd1;
  localparam logic [1:0] CMD_FIN     = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_ADD_FIN,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e                           op;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic valid;
  } queue_ctl_t;

endpackage

@@ design/wst_if.sv @@
// ----------------------------------------------------------------------------
// Window statistics channels
// Valid/ready channels for samples, results and the window size register.
// ----------------------------------------------------------------------------
interface wst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] sample;
  modport source (output valid, cmd, sample, input ready);
  modport sink (input valid, cmd, sample, output ready);
endinterface

interface wst_out_if;
  logic               valid;
  logic               ready;
  logic [10:0]        count;
  logic signed [23:0] mean;
  logic [37:0]        variance;
  logic [23:0]        std_dev;
  logic signed [15:0] minimum;
  logic signed [15:0] maximum;
  logic [15:0]        spread;
  modport source (output valid, count, mean, variance, std_dev, minimum, maximum, spread,
                  input ready);
  modport sink (input valid, count, mean, variance, std_dev, minimum, maximum, spread,
                output ready);
endinterface

interface wst_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ design/wst_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/wst_front.sv @@
// ----------------------------------------------------------------------------
// Window statistics front end
// Accepts commands, drops the unused code and queues work for the back end.
// ----------------------------------------------------------------------------
`include "window_statistics_top_assert.svh"
module wst_front import wst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  wst_in_if.sink     in_if,
  input  logic       pop_i,
  output queue_ctl_t ctl_o,
  output item_t      head_o
);

  localparam int QP_W = $clog2(QUEUE_DEPTH);

  item_t           buf_q [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QP_W:0]   cnt_q, cnt_d;
  logic            accept, push, pop;
  item_t           item;

  assign in_if.ready = (cnt_q != (QP_W+1)'(QUEUE_DEPTH));
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    item.sample = in_if.sample;
    push        = accept;
    case (in_if.cmd)
      CMD_ADD:     item.op = OP_ADD;
      CMD_ADD_FIN: item.op = OP_ADD_FIN;
      CMD_FIN:     item.op = OP_FIN;
      default: begin
        item.op = OP_FIN;
        push    = 1'b0;
      end
    endcase
  end

  assign pop          = pop_i && (cnt_q != '0);
  assign ctl_o.valid  = (cnt_q != '0);
  assign head_o       = buf_q[rd_q];

  always_comb begin
    wr_d  = push ? ((wr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop ? ((rd_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (QP_W+1)'(push) - (QP_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= item;
    end
  end

  `WST_ASSERT(a_cnt_bound, cnt_q <= (QP_W+1)'(QUEUE_DEPTH), "Queue count exceeds depth.")
  `WST_ASSERT_NEXT(a_cmd3_drop, accept && in_if.cmd == CMD_NOP && !pop, cnt_q == $past(cnt_q),
    "Unused command entered the queue.")
  `WST_ASSERT(a_ptr_gap, (cnt_q == '0 || cnt_q == (QP_W+1)'(QUEUE_DEPTH)) ? (wr_q == rd_q)
    : (wr_q != rd_q), "Queue pointers disagree with count.")

endmodule

@@ design/wst_back.sv @@
// ----------------------------------------------------------------------------
// Window statistics back end
// Maintains the sample ring and running sums and computes the statistics.
// ----------------------------------------------------------------------------
`include "window_statistics_top_assert.svh"
module wst_back import wst_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [10:0]  window_size_i,
  input  queue_ctl_t   ctl_i,
  input  item_t        head_i,
  output logic         pop_o,
  wst_out_if.source    out_if
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_FIN, S_DROP_RD, S_DROP, S_MM_RD, S_MM,
    S_MUL, S_DIFF, S_VDIV, S_MDIV, S_SQRT, S_OUT
  } state_e;

  localparam int DSR_W = NN_W - 1;

  state_e                        state_q;
  op_e                           op_q;
  logic signed [SAMPLE_BITS-1:0] smp_q, mn_q, mx_q;
  logic [PTR_W-1:0]              wp_q, idx_q, raddr;
  logic [CNT_W-1:0]              fill_q, n_q, left_q;
  logic signed [SUM_W-1:0]       sum_q, s1_q;
  logic [SQ_W-1:0]               sq_q, s2_q;
  logic [D_W-1:0]                p1_q;
  logic [2*SUM_W-1:0]            p2_q;
  logic [DSR_W-1:0]              nn_q, dsr_q;
  logic [DVD_W-1:0]              dvd_q;
  logic [DSR_W:0]                rem_q;
  logic [6:0]                    dcnt_q;
  logic [RAD_W-1:0]              rad_q, v2_q;
  logic [ROOT_W+1:0]             srem_q;
  logic [ROOT_W-1:0]             root_q;
  logic [4:0]                    scnt_q;
  logic signed [23:0]            mean_q;
  logic                          first_q, out_valid_q;
  logic [SAMPLE_BITS-1:0]        rdata;
  logic signed [SAMPLE_BITS-1:0] old_s;
  logic [CNT_W-1:0]              win_eff, n_new;
  logic [PTR_W+1:0]              start_idx;
  logic [DSR_W:0]                div_sh;
  logic                          div_ge;
  logic [ROOT_W+1:0]             sq_sh, sq_trial;
  logic                          sq_ge;
  logic [SUM_W-1:0]              s1_abs;
  logic [DVD_W-1:0]              dvd_next;
  logic [SUM_W-1:0]              mq;

  wst_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_ring (
    .clk_i  (clk_i),
    .we_i   (state_q == S_ADD),
    .waddr_i(wp_q),
    .wdata_i(smp_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign old_s = rdata;
  assign raddr = (state_q == S_IDLE) ? wp_q : idx_q;
  assign pop_o = (state_q == S_IDLE) && ctl_i.valid;

  always_comb begin
    if (window_size_i == '0) begin
      win_eff = CNT_W'(1);
    end else if (window_size_i > 11'(MAX_WINDOW)) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(window_size_i);
    end
    n_new     = (fill_q < win_eff) ? fill_q : win_eff;
    start_idx = (PTR_W+2)'(wp_q) + (PTR_W+2)'(MAX_WINDOW) - (PTR_W+2)'(fill_q);
    if (start_idx >= (PTR_W+2)'(MAX_WINDOW)) begin
      start_idx = start_idx - (PTR_W+2)'(MAX_WINDOW);
    end
    div_sh   = {rem_q[DSR_W-1:0], dvd_q[DVD_W-1]};
    div_ge   = div_sh >= {1'b0, dsr_q};
    dvd_next = {dvd_q[DVD_W-2:0], div_ge};
    sq_sh    = {srem_q[ROOT_W-1:0], rad_q[RAD_W-1:RAD_W-2]};
    sq_trial = {root_q, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    s1_abs   = s1_q[SUM_W-1] ? SUM_W'(-s1_q) : SUM_W'(s1_q);
    mq       = dvd_next[SUM_W-1:0];
  end

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_if.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (ctl_i.valid) begin
            state_q <= (head_i.op == OP_FIN) ? S_FIN : S_ADD;
          end
        end
        S_ADD: begin
          if (fill_q == CNT_W'(MAX_WINDOW)) begin
            sum_q <= sum_q - SUM_W'(old_s) + SUM_W'(smp_q);
            sq_q  <= sq_q - SQ_W'(old_s * old_s) + SQ_W'(smp_q * smp_q);
          end else begin
            fill_q <= fill_q + 1'b1;
            sum_q  <= sum_q + SUM_W'(smp_q);
            sq_q   <= sq_q + SQ_W'(smp_q * smp_q);
          end
          wp_q    <= ptr_inc(wp_q);
          state_q <= (op_q == OP_ADD_FIN) ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          wp_q   <= '0;
          fill_q <= '0;
          sum_q  <= '0;
          sq_q   <= '0;
          if (n_new == '0) begin
            state_q <= S_OUT;
          end else if (fill_q != n_new) begin
            state_q <= S_DROP_RD;
          end else begin
            state_q <= S_MM_RD;
          end
        end
        S_DROP_RD: state_q <= S_DROP;
        S_DROP:    state_q <= (left_q == CNT_W'(1)) ? S_MM_RD : S_DROP_RD;
        S_MM_RD:   state_q <= S_MM;
        S_MM:      state_q <= (left_q == CNT_W'(1)) ? S_MUL : S_MM_RD;
        S_MUL:     state_q <= S_DIFF;
        S_DIFF:    state_q <= S_VDIV;
        S_VDIV:    state_q <= (dcnt_q == 7'd1) ? S_MDIV : S_VDIV;
        S_MDIV:    state_q <= (dcnt_q == 7'd1) ? S_SQRT : S_MDIV;
        S_SQRT:    state_q <= (scnt_q == 5'd1) ? S_OUT : S_SQRT;
        S_OUT: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q  <= head_i.op;
        smp_q <= head_i.sample;
      end
      S_FIN: begin
        n_q     <= n_new;
        s1_q    <= sum_q;
        s2_q    <= sq_q;
        idx_q   <= start_idx[PTR_W-1:0];
        left_q  <= (fill_q != n_new) ? fill_q - n_new : n_new;
        first_q <= 1'b1;
        mean_q  <= '0;
        v2_q    <= '0;
        root_q  <= '0;
        mn_q    <= '0;
        mx_q    <= '0;
      end
      S_DROP: begin
        s1_q   <= s1_q - SUM_W'(old_s);
        s2_q   <= s2_q - SQ_W'(old_s * old_s);
        idx_q  <= ptr_inc(idx_q);
        left_q <= (left_q == CNT_W'(1)) ? n_q : left_q - 1'b1;
      end
      S_MM: begin
        first_q <= 1'b0;
        if (first_q || old_s < mn_q) begin
          mn_q <= old_s;
        end
        if (first_q || old_s > mx_q) begin
          mx_q <= old_s;
        end
        idx_q  <= ptr_inc(idx_q);
        left_q <= left_q - 1'b1;
      end
      S_MUL: begin
        p1_q <= D_W'(n_q * s2_q);
        p2_q <= (2*SUM_W)'(s1_q * s1_q);
        nn_q <= DSR_W'(n_q * n_q);
      end
      S_DIFF: begin
        dvd_q  <= {p1_q - D_W'(p2_q), 16'd0};
        dsr_q  <= nn_q;
        rem_q  <= '0;
        dcnt_q <= 7'(DVD_W);
      end
      S_VDIV: begin
        if (dcnt_q == 7'd1) begin
          v2_q   <= dvd_next[RAD_W-1:0];
          rad_q  <= dvd_next[RAD_W-1:0];
          dvd_q  <= DVD_W'({s1_abs, 8'd0});
          dsr_q  <= DSR_W'(n_q);
          rem_q  <= '0;
          dcnt_q <= 7'(DVD_W);
          srem_q <= '0;
          root_q <= '0;
          scnt_q <= 5'(ROOT_W);
        end else begin
          rem_q  <= div_ge ? div_sh - {1'b0, dsr_q} : div_sh;
          dvd_q  <= dvd_next;
          dcnt_q <= dcnt_q - 1'b1;
        end
      end
      S_MDIV: begin
        rem_q  <= div_ge ? div_sh - {1'b0, dsr_q} : div_sh;
        dvd_q  <= dvd_next;
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == 7'd1) begin
          mean_q <= s1_q[SUM_W-1] ? 24'(-mq) : 24'(mq);
        end
      end
      S_SQRT: begin
        srem_q <= sq_ge ? sq_sh - sq_trial : sq_sh;
        root_q <= {root_q[ROOT_W-2:0], sq_ge};
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        scnt_q <= scnt_q - 1'b1;
      end
      S_OUT: begin
        if (!out_valid_q || out_if.ready) begin
          out_if.count    <= n_q;
          out_if.mean     <= mean_q;
          out_if.variance <= v2_q[45:8];
          out_if.std_dev  <= root_q;
          out_if.minimum  <= mn_q;
          out_if.maximum  <= mx_q;
          out_if.spread   <= 16'(mx_q - mn_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_if.valid = out_valid_q;

  `WST_ASSERT(a_fill_bound, fill_q <= CNT_W'(MAX_WINDOW), "Fill count exceeds ring depth.")
  `WST_ASSERT_NEXT(a_fin_clears, state_q == S_FIN, fill_q == '0 && sum_q == '0,
    "Finish did not clear the set.")
  `WST_ASSERT_NEXT(a_out_hold, out_valid_q && !out_if.ready, out_valid_q,
    "Pending result dropped.")

endmodule

@@ design/window_statistics_top.sv @@
// ----------------------------------------------------------------------------
// Window statistics top level
// Sliding window mean, variance, deviation, minimum, maximum and spread of samples.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_if    in   cmd, sample
// out_if   out  count, mean, variance, std_dev, minimum, maximum, spread
// cfg_if   in   window size
//
// The back end handles an add in its idle and add states, fed by a four entry queue.
// A finish scans the ring, one read and one update state per entry (up to 1024),
// then runs two 68 bit divides and a 24 bit square root, one bit per cycle each.
// Reset clears the pointer, fill count, sums and queue; the ring needs no clearing.
// The input stalls when the queue is full: adds faster than the back end takes them
// fill it, as does any finish in progress. A result waits in the output register.
module window_statistics_top import wst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  wst_in_if.sink     in_if,
  wst_out_if.source  out_if,
  wst_cfg_if.sink    cfg_if
);

  logic [10:0] window_q;
  queue_ctl_t  ctl;
  item_t       head;
  logic        pop;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 11'(MAX_WINDOW);
    end else if (cfg_if.valid) begin
      window_q <= cfg_if.data;
    end
  end

  wst_front u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .pop_i (pop),
    .ctl_o (ctl),
    .head_o(head)
  );

  wst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .window_size_i(window_q),
    .ctl_i        (ctl),
    .head_i       (head),
    .pop_o        (pop),
    .out_if       (out_if)
  );

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Window statistics testbench
// Drives sample words through the input channel and compares each result word
// with a predictor that keeps its own ring, running sums and window size.
// ----------------------------------------------------------------------------
module testbench import wst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 30000;
  localparam int DRAIN_CYCLES = 64;
  localparam int ITEM_TARGET = 1950;

  typedef struct {
    logic [10:0]        count;
    logic signed [23:0] mean;
    logic [37:0]        variance;
    logic [23:0]        std_dev;
    logic signed [15:0] minimum;
    logic signed [15:0] maximum;
    logic [15:0]        spread;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wst_in_if  in_if ();
  wst_out_if out_if ();
  wst_cfg_if cfg_if ();

  window_statistics_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  int          win_samples [MAX_WINDOW];
  int          win_wr_ptr;
  int          win_fill;
  longint      win_sum;
  longint      win_sq_sum;
  logic [10:0] win_size;

  stats_t pending_stats[$];
  int     words_sent;
  int     results_checked;
  int     finishes_sent;
  int     mismatches;
  int     stall_cycles_left;
  int     quiet_cycles;
  bit     idle_en;
  bit     hold_output;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 12) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void clear_window();
    win_wr_ptr = 0;
    win_fill = 0;
    win_sum = 0;
    win_sq_sum = 0;
  endfunction

  function automatic void push_sample(int s);
    if (win_fill >= MAX_WINDOW) begin
      win_sum -= win_samples[win_wr_ptr];
      win_sq_sum -= longint'(win_samples[win_wr_ptr]) * win_samples[win_wr_ptr];
    end else begin
      win_fill++;
    end
    win_samples[win_wr_ptr] = s;
    win_sum += s;
    win_sq_sum += longint'(s) * s;
    win_wr_ptr = (win_wr_ptr + 1) % MAX_WINDOW;
  endfunction

  function automatic stats_t window_stats();
    stats_t st;
    int w, n, idx, lo, hi;
    longint s1, s2;
    longint unsigned d, nn, q, r, v2;
    st = '{default: '0};
    w = win_size;
    if (w == 0) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    n = (win_fill < w) ? win_fill : w;
    if (n == 0) return st;
    s1 = win_sum;
    s2 = win_sq_sum;
    idx = (win_wr_ptr + MAX_WINDOW - win_fill) % MAX_WINDOW;
    for (int i = 0; i < win_fill - n; i++) begin
      s1 -= win_samples[idx];
      s2 -= longint'(win_samples[idx]) * win_samples[idx];
      idx = (idx + 1) % MAX_WINDOW;
    end
    lo = win_samples[idx];
    hi = lo;
    for (int i = 0; i < n; i++) begin
      if (win_samples[idx] < lo) lo = win_samples[idx];
      if (win_samples[idx] > hi) hi = win_samples[idx];
      idx = (idx + 1) % MAX_WINDOW;
    end
    d = longint'(n) * s2 - s1 * s1;
    nn = longint'(n) * n;
    q = d / nn;
    r = d % nn;
    v2 = q * 65536 + (r * 65536) / nn;
    st.count = n;
    st.mean = (s1 * 256) / n;
    st.variance = (d * 256) / nn;
    st.std_dev = int_sqrt(v2);
    st.minimum = lo;
    st.maximum = hi;
    st.spread = hi - lo;
    return st;
  endfunction

  function automatic void predict_word(logic [1:0] cmd, logic signed [15:0] s);
    if (cmd == CMD_NOP) return;
    if (cmd != CMD_FIN) push_sample(s);
    if (cmd == CMD_ADD) return;
    pending_stats.push_back(window_stats());
    clear_window();
    finishes_sent++;
  endfunction

  task automatic send_word(logic [1:0] cmd, logic signed [15:0] s);
    int gap;
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.cmd = cmd;
    in_if.sample = s;
    do @(posedge clk_i); while (!in_if.ready);
    if (cmd != CMD_NOP) words_sent++;
    predict_word(cmd, s);
    gap = (idle_en && $urandom_range(0, 1)) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(logic [10:0] size);
    wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    cfg_if.valid = 1'b1;
    cfg_if.data = size;
    do @(posedge clk_i); while (!cfg_if.ready);
    win_size = size;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic send_set(int len, bit with_fin_cmd);
    for (int i = 0; i < len - 1; i++) send_word(CMD_ADD, pick_sample());
    if (with_fin_cmd) begin
      send_word(CMD_ADD_FIN, pick_sample());
    end else begin
      send_word(CMD_ADD, pick_sample());
      send_word(CMD_FIN, '0);
    end
  endtask

  task automatic test_extremes();
    write_window(11'd1024);
    send_word(CMD_ADD, 16'sh7fff);
    send_word(CMD_ADD_FIN, 16'sh8000);
    send_word(CMD_ADD, 16'sh8000);
    send_word(CMD_ADD, 16'sh8000);
    send_word(CMD_FIN, '0);
    send_word(CMD_ADD_FIN, 16'sh7fff);
    send_word(CMD_ADD, 16'sh0001);
    send_word(CMD_ADD, 16'sh0002);
    send_word(CMD_ADD_FIN, -16'sd4);
  endtask

  task automatic test_commands();
    send_word(CMD_FIN, '0);
    send_word(CMD_NOP, 16'sh1234);
    send_word(CMD_ADD, 16'sd10);
    send_word(CMD_NOP, 16'sh7fff);
    send_word(CMD_ADD, -16'sd7);
    send_word(CMD_FIN, 16'sh5555);
    send_word(CMD_FIN, '0);
  endtask

  task automatic test_window_limits();
    write_window(11'd0);
    send_set(5, 1'b1);
    write_window(11'd1);
    send_set(4, 1'b0);
    write_window(11'd2047);
    send_set(1030, 1'b1);
    write_window(11'd3);
    send_set(30, 1'b0);
    write_window(11'd1024);
    send_set(20, 1'b1);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_output = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        hold_output = 1'b0;
      end
    join_none
    for (int i = 0; i < 8; i++) send_set($urandom_range(1, 5), i[0]);
    wait_drained();
    idle_en = 1'b0;
    for (int i = 0; i < 6; i++) send_set($urandom_range(1, 8), 1'b1);
    idle_en = 1'b1;
  endtask

  task automatic test_random();
    int r, len, next_cfg;
    next_cfg = words_sent + 300;
    while (words_sent < ITEM_TARGET) begin
      if (words_sent >= next_cfg) begin
        next_cfg = words_sent + 300;
        idle_en = $urandom_range(0, 3) != 0;
        r = $urandom_range(0, 4);
        write_window(r == 0 ? 11'($urandom_range(0, 2047)) :
                     r == 1 ? 11'd1024 : 11'($urandom_range(1, 40)));
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_word(CMD_NOP, pick_sample());
      end else if (r < 6) begin
        send_word(CMD_FIN, 16'($urandom_range(0, 65535)));
      end else begin
        r = $urandom_range(0, 99);
        len = (r < 85) ? $urandom_range(1, 24) : (r < 98) ? $urandom_range(25, 120) :
              $urandom_range(900, 1100);
        if (len > ITEM_TARGET - words_sent) len = ITEM_TARGET - words_sent;
        send_set(len, $urandom_range(0, 1));
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_output) begin
      out_if.ready = 1'b0;
    end else if (!idle_en) begin
      out_if.ready = 1'b1;
    end else if (stall_cycles_left > 0) begin
      stall_cycles_left--;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
      if ($urandom_range(0, 3) == 0) stall_cycles_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    stats_t exp_st;
    bit bad;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word, count %0d", out_if.count);
      end else begin
        exp_st = pending_stats.pop_front();
        results_checked++;
        bad = exp_st.count !== out_if.count || exp_st.mean !== out_if.mean ||
              exp_st.variance !== out_if.variance || exp_st.std_dev !== out_if.std_dev ||
              exp_st.minimum !== out_if.minimum || exp_st.maximum !== out_if.maximum ||
              exp_st.spread !== out_if.spread;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result %0d mismatch:", results_checked);
            $display("  expected n=%0d mean=%0d var=%0d sd=%0d min=%0d max=%0d spread=%0d",
                     exp_st.count, exp_st.mean, exp_st.variance, exp_st.std_dev,
                     exp_st.minimum, exp_st.maximum, exp_st.spread);
            $display("  actual   n=%0d mean=%0d var=%0d sd=%0d min=%0d max=%0d spread=%0d",
                     out_if.count, out_if.mean, out_if.variance, out_if.std_dev,
                     out_if.minimum, out_if.maximum, out_if.spread);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = CMD_ADD;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    idle_en = 1'b1;
    hold_output = 1'b0;
    stall_cycles_left = 0;
    quiet_cycles = 0;
    words_sent = 0;
    results_checked = 0;
    finishes_sent = 0;
    mismatches = 0;
    win_size = 11'd1024;
    clear_window();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_commands();
    test_window_limits();
    test_backpressure();
    test_random();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    wait_drained();
    $display("Covered %0d sample words and %0d finished sets, window sizes 0 to 2047,",
             words_sent, finishes_sent);
    $display("ring wrap, empty sets, ignored commands and output back-pressure.");
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
